// ----- hdl/abdd_pkg.sv -----
// Shared types, widths and defaults for the bit-deinterleaving deserializer.
package abdd_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned NibbleW         = 4;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned ChannelW        = 3;
  localparam int unsigned BytePosW        = 2;
  localparam int unsigned PairsPerFrameDefault = 8;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [SampleW-1:0]  sample_t;
  typedef logic [ChannelW-1:0] channel_t;
  typedef logic [BytePosW-1:0] byte_pos_t;

  typedef struct packed {
    channel_t low_channel;
    sample_t  sample_a;
    sample_t  sample_b;
    logic     frame_last;
  } result_t;

  // Place nibble bits 3,2,1,0 at sample bits 3,7,11,15, then shift down by the byte position.
  function automatic sample_t spread_nibble(input logic [NibbleW-1:0] nib, input byte_pos_t k);
    sample_t v;
    v = {nib[0], 3'b000, nib[1], 3'b000, nib[2], 3'b000, nib[3], 3'b000};
    return v >> k;
  endfunction

endpackage

// ----- hdl/abdd_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
interface abdd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/abdd_assembler.sv -----
// Byte accumulator and pair counter: builds both samples of a group of four bytes.
module abdd_assembler #(
  parameter int unsigned PAIRS_PER_FRAME = abdd_pkg::PairsPerFrameDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  abdd_pkg::byte_t   data_byte,
  output logic              done,
  output abdd_pkg::result_t result
);

  localparam abdd_pkg::channel_t LastPair = abdd_pkg::ChannelW'(PAIRS_PER_FRAME - 1);

  abdd_pkg::byte_pos_t byte_position;
  abdd_pkg::channel_t  pair_position;
  abdd_pkg::sample_t   accum_a;
  abdd_pkg::sample_t   accum_b;
  abdd_pkg::sample_t   accum_a_next;
  abdd_pkg::sample_t   accum_b_next;
  logic                last;

  always_comb begin
    accum_a_next = accum_a | abdd_pkg::spread_nibble(data_byte[7:4], byte_position);
    accum_b_next = accum_b | abdd_pkg::spread_nibble(data_byte[3:0], byte_position);
    done         = take && (byte_position == abdd_pkg::byte_pos_t'(3));
    last         = (pair_position >= LastPair);
    result.low_channel = pair_position + abdd_pkg::channel_t'(1);
    result.sample_a    = accum_a_next;
    result.sample_b    = accum_b_next;
    result.frame_last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pair_position <= '0;
      accum_a       <= '0;
      accum_b       <= '0;
    end else if (take) begin
      byte_position <= byte_position + abdd_pkg::byte_pos_t'(1);
      if (done) begin
        // group complete: clear the accumulators and advance the pair
        accum_a       <= '0;
        accum_b       <= '0;
        pair_position <= last ? '0 : pair_position + abdd_pkg::channel_t'(1);
      end else begin
        accum_a <= accum_a_next;
        accum_b <= accum_b_next;
      end
    end
  end

endmodule

// ----- hdl/adc_bit_deinterleave_deserializer_core.sv -----
// Top level of the bit-deinterleaving deserializer for a 16-channel converter link.
//
//   channel   dir    payload                                        request
//   din       sink   data_byte[7:0]                                 one raw link byte
//   dout      source low_channel[2:0] sample_a[15:0] sample_b[15:0] one sample pair
//                    frame_last
//
// One byte is taken per cycle while din is ready; every fourth byte loads the
// result register, so a pair appears in the cycle after the byte that completes
// it. The single result register sets the pace: din stays ready while it is
// empty or being drained. Synchronous reset clears the byte and pair counters,
// the accumulators and the result valid. A stall on dout holds the result and
// blocks din for as long as the result waits, whichever byte of a group is offered.
module adc_bit_deinterleave_deserializer_core #(
  parameter int unsigned PAIRS_PER_FRAME = abdd_pkg::PairsPerFrameDefault
) (
  input logic   clk,
  input logic   rst,
  abdd_stream_if.sink   din,
  abdd_stream_if.source dout
);

  logic              take;
  logic              done;
  abdd_pkg::result_t result;
  abdd_pkg::result_t result_reg;
  logic              out_valid;

  assign din.ready    = !out_valid || dout.ready;
  assign take         = din.valid && din.ready;
  assign dout.valid   = out_valid;
  assign dout.payload = result_reg;

  abdd_assembler #(
    .PAIRS_PER_FRAME(PAIRS_PER_FRAME)
  ) u_assembler (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (din.payload),
    .done      (done),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_reg <= result;
    end
  end

endmodule
